/* rtl/lgge_pkg.sv */
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared request codes, register indexes and controller/datapath interface
// structs for the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_TOGGLE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_STEP   = 2'd3;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_req;
        logic cnt_clear;
        logic cnt_inc;
        logic clear_wr;
        logic cell_wb;
        logic sweep;
        logic step_done;
    } lgge_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_step;
        logic sweep_last;
    } lgge_status_t;

endpackage

/* rtl/lgge_ctrl.sv */
// ----------------------------------------------------------------------------
// lgge_ctrl
// Sequencer for the life engine: clearing pass after reset, request dispatch,
// single cell read-modify-write and the row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lgge_ctrl
    import lgge_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  lgge_status_t status,
    output lgge_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_CELL_WB,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                // cell row read is issued here; sweep counter starts over
                cmd.cnt_clear = 1'b1;
                if (status.is_step)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_CELL_WB;
                end
            end
            ST_CELL_WB:
            begin
                cmd.cell_wb = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.step_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* rtl/lgge_datapath.sv */
// ----------------------------------------------------------------------------
// lgge_datapath
// Row-wide grid memory, request registers, configuration registers, sweep
// counter, B3/S23 row update and the result register.
// ----------------------------------------------------------------------------
module lgge_datapath
    import lgge_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lgge_cmd_t          cmd,
    output lgge_status_t       status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [1:0]         req_type,
    input  logic [5:0]         cell_row,
    input  logic [5:0]         cell_col,
    input  logic               write_value,
    output logic               done,
    output logic               cell_state,
    output logic               out_of_range
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RCW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
    localparam int NW  = $clog2(MAX_ROWS + 2);

    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_q_reg;

    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    logic [NW-1:0]    cnt_reg;

    logic [1:0]          req_type_reg;
    logic [RAW-1:0]      req_row_reg;
    logic [CAW-1:0]      req_col_reg;
    logic                req_wval_reg;
    logic                req_flag_reg;

    logic [MAX_COLS-1:0] above_reg;
    logic [MAX_COLS-1:0] cur_reg;

    logic done_reg;
    logic cell_state_reg;
    logic out_of_range_reg;

    logic [RCW-1:0]      eff_rows;
    logic [CCW-1:0]      eff_cols;
    logic [NW-1:0]       nrows;
    logic [RCW-1:0]      row_ext;
    logic [CCW-1:0]      col_ext;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] below_row;
    logic [MAX_COLS-1:0] life_row;
    logic [MAX_COLS-1:0] cell_row_new;
    logic                cell_bit_new;
    logic                sweep_rd;
    logic                sweep_load;
    logic                sweep_wr;
    logic [NW-1:0]       sweep_wr_cnt;
    logic                mem_we;
    logic [RAW-1:0]      mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic [RAW-1:0]      mem_raddr;

    // registers above the parameter limits clamp to it
    always_comb
    begin
        if (RCW'(rows_cfg_reg) > RCW'(MAX_ROWS))
        begin
            eff_rows = RCW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = RCW'(rows_cfg_reg);
        end
        if (CCW'(cols_cfg_reg) > CCW'(MAX_COLS))
        begin
            eff_cols = CCW'(MAX_COLS);
        end
        else
        begin
            eff_cols = CCW'(cols_cfg_reg);
        end
    end

    assign nrows   = eff_rows[NW-1:0];
    assign row_ext = RCW'(cell_row);
    assign col_ext = CCW'(cell_col);

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = (CCW'(c) < eff_cols);
        end
    end

    // sweep schedule: read row cnt, load row cnt-1, update row cnt-2
    assign sweep_rd     = cmd.sweep && (cnt_reg < nrows);
    assign sweep_load   = cmd.sweep && (cnt_reg != '0) && (cnt_reg <= nrows);
    assign sweep_wr     = cmd.sweep && (cnt_reg >= NW'(2));
    assign sweep_wr_cnt = cnt_reg - NW'(2);
    assign below_row    = (cnt_reg == nrows + NW'(1)) ? '0 : rd_q_reg;

    assign status.clear_last = (cnt_reg == NW'(MAX_ROWS - 1));
    assign status.is_step    = (req_type_reg == REQ_STEP);
    assign status.sweep_last = (cnt_reg == nrows + NW'(1));

    // B3/S23 over one row, columns outside the region keep their old value
    always_comb
    begin
        logic [MAX_COLS+1:0] ap;
        logic [MAX_COLS+1:0] mp;
        logic [MAX_COLS+1:0] bp;
        logic [3:0]          n;
        ap = {1'b0, above_reg & col_mask, 1'b0};
        mp = {1'b0, cur_reg & col_mask, 1'b0};
        bp = {1'b0, below_row & col_mask, 1'b0};
        for (int c = 0; c < MAX_COLS; c++)
        begin
            n = 4'(ap[c]) + 4'(mp[c]) + 4'(bp[c])
              + 4'(ap[c+1]) + 4'(bp[c+1])
              + 4'(ap[c+2]) + 4'(mp[c+2]) + 4'(bp[c+2]);
            if (!col_mask[c])
            begin
                life_row[c] = cur_reg[c];
            end
            else if (mp[c+1])
            begin
                life_row[c] = (n == 4'd2) || (n == 4'd3);
            end
            else
            begin
                life_row[c] = (n == 4'd3);
            end
        end
    end

    // single cell read-modify-write
    always_comb
    begin
        case (req_type_reg)
            REQ_WRITE:  cell_bit_new = req_wval_reg;
            REQ_TOGGLE: cell_bit_new = ~rd_q_reg[req_col_reg];
            default:    cell_bit_new = rd_q_reg[req_col_reg];
        endcase
        cell_row_new              = rd_q_reg;
        cell_row_new[req_col_reg] = cell_bit_new;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = req_row_reg;
        mem_wdata = cell_row_new;
        if (cmd.clear_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[RAW-1:0];
            mem_wdata = '0;
        end
        else if (sweep_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_wr_cnt[RAW-1:0];
            mem_wdata = life_row;
        end
        else if (cmd.cell_wb && !req_flag_reg && (req_type_reg != REQ_READ))
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.sweep)
        begin
            mem_raddr = sweep_rd ? cnt_reg[RAW-1:0] : '0;
        end
        else
        begin
            mem_raddr = req_row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_q_reg <= grid_mem[mem_raddr];
    end

    // request, row window and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_type_reg <= req_type;
            req_row_reg  <= row_ext[RAW-1:0];
            req_col_reg  <= col_ext[CAW-1:0];
            req_wval_reg <= write_value;
            req_flag_reg <= (req_type != REQ_STEP)
                         && ((row_ext >= eff_rows) || (col_ext >= eff_cols));
        end
        if (cmd.cnt_clear)
        begin
            above_reg <= '0;
            cur_reg   <= '0;
        end
        else if (sweep_load)
        begin
            above_reg <= cur_reg;
            cur_reg   <= rd_q_reg;
        end
        if (cmd.cell_wb)
        begin
            cell_state_reg   <= req_flag_reg ? 1'b0 : cell_bit_new;
            out_of_range_reg <= req_flag_reg;
        end
        else if (cmd.step_done)
        begin
            cell_state_reg   <= 1'b0;
            out_of_range_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= CFG_RESET;
            cols_cfg_reg <= CFG_RESET;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_ROWS))
            begin
                rows_cfg_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_COLS))
            begin
                cols_cfg_reg <= cfg_data;
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            done_reg <= cmd.cell_wb || cmd.step_done;
        end
    end

    assign done         = done_reg;
    assign cell_state   = cell_state_reg;
    assign out_of_range = out_of_range_reg;

    a_sweep_wr_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_wr |-> (sweep_wr_cnt < nrows))
        else $error("sweep update outside rows in use");

    a_flag_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cell_wb && req_flag_reg) |-> !mem_we)
        else $error("flagged request wrote the grid");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cell_wb || cmd.step_done) |=> (done && !(cell_state && out_of_range)))
        else $error("result strobe missing or inconsistent");

    a_load_before_update: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep_wr && !status.sweep_last) |-> sweep_load)
        else $error("row window not advanced during update");

endmodule

/* rtl/life_grid_generation_engine_top.sv */
// ----------------------------------------------------------------------------
// life_grid_generation_engine_top
// Conway B3/S23 grid engine: cell write, toggle, read and generation step.
// ----------------------------------------------------------------------------
// cell request: dispatch, write-back, done strobe; next request taken while done is high
// step: the sweep updates one row per cycle through the single read and single write
//   port of the row memory
// reset: busy stays high while the grid is cleared,
//   config writes are taken during that pass
// results are a one-cycle strobe on done, the receiver cannot stall
module life_grid_generation_engine_top
    import lgge_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       req_type,
    input  logic [5:0]       cell_row,
    input  logic [5:0]       cell_col,
    input  logic             write_value,
    output logic             done,
    output logic             cell_state,
    output logic             out_of_range,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    lgge_cmd_t    cmd;
    lgge_status_t status;

    lgge_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lgge_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .write_value  (write_value),
        .done         (done),
        .cell_state   (cell_state),
        .out_of_range (out_of_range)
    );

endmodule
